[hw/rtl/bmms_pkg.sv]
`default_nettype none

package bmms_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_DRIVE_LIMIT   = 3'd0,
        CFG_PICKUP_TICKS  = 3'd1,
        CFG_PUTDOWN_TICKS = 3'd2,
        CFG_UPRIGHT_TICKS = 3'd3,
        CFG_UPRIGHT_DRIVE = 3'd4
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 15;
    localparam int unsigned DRIVE_W     = 15;
    localparam int unsigned TICKS_W     = 10;
    localparam int unsigned COUNT_W     = 11;
    localparam int unsigned TERM_W      = 16;
    localparam int unsigned ANGLE_W     = 12;
    localparam int unsigned CMD_W       = 16;

    // Increment applied to the supervisor counters.
    localparam logic [COUNT_W-1:0] COUNT_STEP = COUNT_W'(1);

    // Reset values of the configuration registers.
    localparam logic [DRIVE_W-1:0] DRIVE_LIMIT_RST   = 15'd7000;
    localparam logic [TICKS_W-1:0] PICKUP_TICKS_RST  = 10'd200;
    localparam logic [TICKS_W-1:0] PUTDOWN_TICKS_RST = 10'd200;
    localparam logic [TICKS_W-1:0] UPRIGHT_TICKS_RST = 10'd300;
    localparam logic [DRIVE_W-1:0] UPRIGHT_DRIVE_RST = 15'd1800;

    // Command word bits.
    localparam int unsigned CMD_HALT_BIT  = 3;
    localparam int unsigned CMD_LEFT_BIT  = 12;
    localparam int unsigned CMD_RIGHT_BIT = 14;

    // Attitude thresholds in tenths of a degree.
    localparam logic signed [ANGLE_W-1:0] LEVEL_PITCH  = 12'sd50;
    localparam logic signed [ANGLE_W-1:0] LEVEL_ROLL   = 12'sd100;
    localparam logic signed [ANGLE_W-1:0] ON_END_ROLL  = 12'sd890;
    localparam logic signed [ANGLE_W-1:0] UPRIGHT_ROLL = 12'sd800;

endpackage

`default_nettype wire

[hw/rtl/balance_motor_mix_supervisor_top.sv]
`default_nettype none
// An input transfer is captured in the input register and then moves into the result
// register. Throughput: one item per cycle unless the output stalls; the supervisor
// state updates in the same cycle that an item moves from the input register into
// the result register.
// Reset: rst_n is asynchronous and active low; it empties both stages, clears all
// counters and flags, and loads the configuration registers with their default values.

module balance_motor_mix_supervisor_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [bmms_pkg::TERM_W-1:0]    balance_term,
    input  wire logic signed [bmms_pkg::TERM_W-1:0]    velocity_term,
    input  wire logic signed [bmms_pkg::TERM_W-1:0]    turn_term,
    input  wire logic signed [bmms_pkg::ANGLE_W-1:0]   pitch_angle,
    input  wire logic signed [bmms_pkg::ANGLE_W-1:0]   roll_angle,
    input  wire logic        [bmms_pkg::CMD_W-1:0]     command_word,
    // Output channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed      [bmms_pkg::TERM_W-1:0]    left_drive,
    output logic signed      [bmms_pkg::TERM_W-1:0]    right_drive,
    output logic                                       stopped,
    output logic                                       lifted,
    output logic                                       upright,
    // Configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic        [bmms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic        [bmms_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index beyond
    // the register list is dropped.
    // ------------------------------------------------------------------
    logic [bmms_pkg::DRIVE_W-1:0] drive_limit_reg;
    logic [bmms_pkg::TICKS_W-1:0] pickup_ticks_reg;
    logic [bmms_pkg::TICKS_W-1:0] putdown_ticks_reg;
    logic [bmms_pkg::TICKS_W-1:0] upright_ticks_reg;
    logic [bmms_pkg::DRIVE_W-1:0] upright_drive_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_limit_reg   <= bmms_pkg::DRIVE_LIMIT_RST;
            pickup_ticks_reg  <= bmms_pkg::PICKUP_TICKS_RST;
            putdown_ticks_reg <= bmms_pkg::PUTDOWN_TICKS_RST;
            upright_ticks_reg <= bmms_pkg::UPRIGHT_TICKS_RST;
            upright_drive_reg <= bmms_pkg::UPRIGHT_DRIVE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bmms_pkg::CFG_DRIVE_LIMIT:   drive_limit_reg   <= cfg_data;
                bmms_pkg::CFG_PICKUP_TICKS:  pickup_ticks_reg  <= cfg_data[bmms_pkg::TICKS_W-1:0];
                bmms_pkg::CFG_PUTDOWN_TICKS: putdown_ticks_reg <= cfg_data[bmms_pkg::TICKS_W-1:0];
                bmms_pkg::CFG_UPRIGHT_TICKS: upright_ticks_reg <= cfg_data[bmms_pkg::TICKS_W-1:0];
                bmms_pkg::CFG_UPRIGHT_DRIVE: upright_drive_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The result register frees up whenever it is empty or
    // its transfer completes, so the input register moves forward every
    // cycle unless the output side stalls with a result waiting.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_free;
    logic s1_advance;
    logic in_accept;

    assign out_free   = !out_valid || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;

    // Input register
    logic signed [bmms_pkg::TERM_W-1:0]  s1_balance_reg;
    logic signed [bmms_pkg::TERM_W-1:0]  s1_velocity_reg;
    logic signed [bmms_pkg::TERM_W-1:0]  s1_turn_reg;
    logic signed [bmms_pkg::ANGLE_W-1:0] s1_pitch_reg;
    logic signed [bmms_pkg::ANGLE_W-1:0] s1_roll_reg;
    logic        [bmms_pkg::CMD_W-1:0]   s1_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_balance_reg  <= balance_term;
            s1_velocity_reg <= velocity_term;
            s1_turn_reg     <= turn_term;
            s1_pitch_reg    <= pitch_angle;
            s1_roll_reg     <= roll_angle;
            s1_cmd_reg      <= command_word;
        end
    end

    // ------------------------------------------------------------------
    // Supervisor state
    // ------------------------------------------------------------------
    logic [bmms_pkg::COUNT_W-1:0] pickup_count_reg,  pickup_count_next;
    logic [bmms_pkg::COUNT_W-1:0] putdown_count_reg, putdown_count_next;
    logic [bmms_pkg::COUNT_W-1:0] upright_count_reg, upright_count_next;
    logic stop_flag_reg,    stop_flag_next;
    logic lifted_flag_reg,  lifted_flag_next;
    logic upright_flag_reg, upright_flag_next;
    logic halt_latch_reg,   halt_latch_next;

    logic signed [bmms_pkg::TERM_W-1:0] left_next, right_next;

    // Mix arithmetic runs 18 bits wide so that B - V +/- T never wraps.
    logic signed [17:0] base;
    logic signed [17:0] mix_l, mix_r;
    logic signed [17:0] lim_pos, lim_neg;
    logic signed [17:0] clamp_l, clamp_r;
    logic signed [bmms_pkg::TERM_W-1:0] sat_l, sat_r;
    logic signed [bmms_pkg::TERM_W-1:0] lim16;
    logic saturated;
    logic is_level;
    logic on_end;

    always_comb
    begin
        base = $signed({{2{s1_balance_reg[15]}}, s1_balance_reg})
             - $signed({{2{s1_velocity_reg[15]}}, s1_velocity_reg});

        // The left turn bit wins when both turn bits are set.
        if (s1_cmd_reg[bmms_pkg::CMD_LEFT_BIT])
        begin
            mix_l = base;
            mix_r = base + $signed({{2{s1_turn_reg[15]}}, s1_turn_reg});
        end
        else if (s1_cmd_reg[bmms_pkg::CMD_RIGHT_BIT])
        begin
            mix_l = base - $signed({{2{s1_turn_reg[15]}}, s1_turn_reg});
            mix_r = base;
        end
        else
        begin
            mix_l = base + $signed({{2{s1_turn_reg[15]}}, s1_turn_reg});
            mix_r = base - $signed({{2{s1_turn_reg[15]}}, s1_turn_reg});
        end

        lim_pos = $signed({3'b000, drive_limit_reg});
        lim_neg = -lim_pos;

        if (mix_l > lim_pos)
        begin
            clamp_l = lim_pos;
        end
        else if (mix_l < lim_neg)
        begin
            clamp_l = lim_neg;
        end
        else
        begin
            clamp_l = mix_l;
        end

        if (mix_r > lim_pos)
        begin
            clamp_r = lim_pos;
        end
        else if (mix_r < lim_neg)
        begin
            clamp_r = lim_neg;
        end
        else
        begin
            clamp_r = mix_r;
        end

        sat_l = clamp_l[15:0];
        sat_r = clamp_r[15:0];
        lim16 = $signed({1'b0, drive_limit_reg});

        // A zero limit clamps both drives to zero, which also counts here.
        saturated = ((sat_l == lim16) && (sat_r == lim16))
                 || ((sat_l == -lim16) && (sat_r == -lim16));

        is_level = (s1_pitch_reg < bmms_pkg::LEVEL_PITCH)
                && (s1_pitch_reg > -bmms_pkg::LEVEL_PITCH)
                && (s1_roll_reg > -bmms_pkg::LEVEL_ROLL)
                && (s1_roll_reg < bmms_pkg::LEVEL_ROLL);

        on_end = (s1_roll_reg > bmms_pkg::ON_END_ROLL)
              || (s1_roll_reg < -bmms_pkg::ON_END_ROLL);

        pickup_count_next  = pickup_count_reg;
        putdown_count_next = putdown_count_reg;
        upright_count_next = upright_count_reg;
        stop_flag_next     = stop_flag_reg;
        lifted_flag_next   = lifted_flag_reg;
        upright_flag_next  = upright_flag_reg;
        left_next          = sat_l;
        right_next         = sat_r;

        // Pick-up: the upright flag drops on every saturated tick, not only
        // when the count runs out.
        if (!lifted_flag_next && saturated)
        begin
            pickup_count_next = pickup_count_reg + bmms_pkg::COUNT_STEP;
            if (pickup_count_next > {1'b0, pickup_ticks_reg})
            begin
                stop_flag_next    = 1'b1;
                lifted_flag_next  = 1'b1;
                pickup_count_next = '0;
            end
            upright_flag_next = 1'b0;
        end

        // Put-down, seen against the lifted flag as the pick-up step left it.
        if (lifted_flag_next && is_level)
        begin
            putdown_count_next = putdown_count_reg + bmms_pkg::COUNT_STEP;
            if (putdown_count_next > {1'b0, putdown_ticks_reg})
            begin
                stop_flag_next     = 1'b0;
                lifted_flag_next   = 1'b0;
                putdown_count_next = '0;
            end
        end

        // Standing on end while lifted enters the upright mode.
        if (lifted_flag_next && !upright_flag_next && on_end)
        begin
            upright_count_next = upright_count_reg + bmms_pkg::COUNT_STEP;
            if (upright_count_next > {1'b0, upright_ticks_reg})
            begin
                stop_flag_next     = 1'b0;
                lifted_flag_next   = 1'b0;
                upright_flag_next  = 1'b1;
                upright_count_next = '0;
            end
        end

        // Past UPRIGHT_ROLL, upright mode drives a single wheel chosen by the lean.
        if (upright_flag_next && (s1_roll_reg > bmms_pkg::UPRIGHT_ROLL))
        begin
            left_next      = $signed({1'b0, upright_drive_reg});
            right_next     = '0;
            stop_flag_next = 1'b0;
        end
        else if (upright_flag_next && (s1_roll_reg < -bmms_pkg::UPRIGHT_ROLL))
        begin
            left_next      = '0;
            right_next     = $signed({1'b0, upright_drive_reg});
            stop_flag_next = 1'b0;
        end

        // The halt latch from the previous tick forces zero drive too.
        if (stop_flag_next || halt_latch_reg)
        begin
            left_next  = '0;
            right_next = '0;
        end

        halt_latch_next = s1_cmd_reg[bmms_pkg::CMD_HALT_BIT];
        if (halt_latch_next)
        begin
            left_next  = '0;
            right_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pickup_count_reg  <= '0;
            putdown_count_reg <= '0;
            upright_count_reg <= '0;
            stop_flag_reg     <= 1'b0;
            lifted_flag_reg   <= 1'b0;
            upright_flag_reg  <= 1'b0;
            halt_latch_reg    <= 1'b0;
        end
        else if (s1_advance)
        begin
            pickup_count_reg  <= pickup_count_next;
            putdown_count_reg <= putdown_count_next;
            upright_count_reg <= upright_count_next;
            stop_flag_reg     <= stop_flag_next;
            lifted_flag_reg   <= lifted_flag_next;
            upright_flag_reg  <= upright_flag_next;
            halt_latch_reg    <= halt_latch_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic signed [bmms_pkg::TERM_W-1:0] left_reg, right_reg;
    logic stopped_reg, lifted_reg, upright_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            left_reg    <= left_next;
            right_reg   <= right_next;
            stopped_reg <= stop_flag_next;
            lifted_reg  <= lifted_flag_next;
            upright_reg <= upright_flag_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign stopped     = stopped_reg;
    assign lifted      = lifted_reg;
    assign upright     = upright_reg;

endmodule

`default_nettype wire

[hw/rtl/bmms_checker.sv]
`default_nettype none

module bmms_checker (
    input wire logic                                    clk,
    input wire logic                                    rst_n,
    input wire logic                                    out_valid,
    input wire logic                                    out_stall,
    input wire logic signed [bmms_pkg::TERM_W-1:0]      left_drive,
    input wire logic signed [bmms_pkg::TERM_W-1:0]      right_drive,
    input wire logic                                    stopped,
    input wire logic                                    lifted,
    input wire logic                                    upright
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_drive)
            && $stable(right_drive) && $stable(stopped))
        else $error("stalled result changed");

    // A stopped robot never drives a wheel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped |-> (left_drive == '0) && (right_drive == '0))
        else $error("drive while stopped");

    // Upright mode is only entered by leaving the lifted state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(upright && lifted))
        else $error("upright and lifted together");

    // Pick-up always sets stop; only put-down or upright entry clears both.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lifted |-> stopped)
        else $error("lifted without stop");

endmodule

bind balance_motor_mix_supervisor_top bmms_checker u_bmms_checker (.*);

`default_nettype wire

[tb/sv/tb_balance_motor_mix_supervisor_top.sv]
module tb_balance_motor_mix_supervisor_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Command word bits and attitude thresholds in tenths of a degree, kept apart from
    // the package so that the prediction does not lean on the design's own constants.
    localparam int LEFT_TURN_BIT  = 12;
    localparam int RIGHT_TURN_BIT = 14;
    localparam int HALT_CMD_BIT   = 3;
    localparam int PITCH_LEVEL    = 50;
    localparam int ROLL_LEVEL     = 100;
    localparam int ROLL_ON_END    = 890;
    localparam int ROLL_TILT      = 800;
    localparam int COUNT_MASK     = 'h7FF;

    localparam logic [15:0] CMD_LEFT  = 16'(1) << LEFT_TURN_BIT;
    localparam logic [15:0] CMD_RIGHT = 16'(1) << RIGHT_TURN_BIT;
    localparam logic [15:0] CMD_HALT  = 16'(1) << HALT_CMD_BIT;

    // Register indexes that select no register at all.
    localparam logic [bmms_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [bmms_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    // The result register sits two stages behind the input, so the settling wait
    // after the last result is plenty before a register write or the end of the run.
    localparam int SETTLE_CYCLES    = 6;
    localparam int LONG_HOLD_AT     = 200;
    localparam int LONG_HOLD_CYCLES = 80;
    // Longest idle burst on either side.
    localparam int MAX_IDLE         = 17;

    typedef struct {
        logic signed [bmms_pkg::TERM_W-1:0]  balance;
        logic signed [bmms_pkg::TERM_W-1:0]  velocity;
        logic signed [bmms_pkg::TERM_W-1:0]  turn;
        logic signed [bmms_pkg::ANGLE_W-1:0] pitch;
        logic signed [bmms_pkg::ANGLE_W-1:0] roll;
        logic        [bmms_pkg::CMD_W-1:0]   cmd;
    } tick_in_t;

    typedef struct {
        logic signed [bmms_pkg::TERM_W-1:0] left;
        logic signed [bmms_pkg::TERM_W-1:0] right;
        logic                               stopped;
        logic                               lifted;
        logic                               upright;
    } drive_out_t;

    // Flavors of generated ticks: full noise, both wheels driven hard the same way,
    // level attitude, standing on end, and tilted far enough for the upright drive.
    typedef enum {
        GEN_NOISE,
        GEN_SATURATE,
        GEN_LEVEL,
        GEN_ON_END,
        GEN_TILT
    } tick_kind_t;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // Every input of the block starts at a known value.
    logic                                in_valid      = 1'b0;
    logic                                in_stall;
    logic signed [bmms_pkg::TERM_W-1:0]  balance_term  = '0;
    logic signed [bmms_pkg::TERM_W-1:0]  velocity_term = '0;
    logic signed [bmms_pkg::TERM_W-1:0]  turn_term     = '0;
    logic signed [bmms_pkg::ANGLE_W-1:0] pitch_angle   = '0;
    logic signed [bmms_pkg::ANGLE_W-1:0] roll_angle    = '0;
    logic        [bmms_pkg::CMD_W-1:0]   command_word  = '0;
    logic                                out_valid;
    logic                                out_stall     = 1'b0;
    logic signed [bmms_pkg::TERM_W-1:0]  left_drive;
    logic signed [bmms_pkg::TERM_W-1:0]  right_drive;
    logic                                stopped;
    logic                                lifted;
    logic                                upright;
    logic                                cfg_valid     = 1'b0;
    logic                                cfg_ready;
    logic [bmms_pkg::CFG_INDEX_W-1:0]    cfg_index     = '0;
    logic [bmms_pkg::CFG_DATA_W-1:0]     cfg_data      = '0;

    balance_motor_mix_supervisor_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .balance_term  (balance_term),
        .velocity_term (velocity_term),
        .turn_term     (turn_term),
        .pitch_angle   (pitch_angle),
        .roll_angle    (roll_angle),
        .command_word  (command_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_drive    (left_drive),
        .right_drive   (right_drive),
        .stopped       (stopped),
        .lifted        (lifted),
        .upright       (upright),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the configuration registers, loaded with their reset values and
    // updated whenever a write transfer completes.
    logic [14:0] limit_cfg   = 15'd7000;
    logic [9:0]  pickup_cfg  = 10'd200;
    logic [9:0]  putdown_cfg = 10'd200;
    logic [9:0]  upright_cfg = 10'd300;
    logic [14:0] udrive_cfg  = 15'd1800;

    // Shadow copy of the supervisor state.
    int pickup_cnt  = 0;
    int putdown_cnt = 0;
    int upright_cnt = 0;
    bit stop_st     = 1'b0;
    bit lifted_st   = 1'b0;
    bit upright_st  = 1'b0;
    bit halt_st     = 1'b0;

    // Ticks waiting to be offered, and the drives and flags still owed by the block.
    tick_in_t   tick_q[$];
    drive_out_t drive_expect_q[$];
    tick_in_t   tick_on_bus;
    drive_out_t result_due;

    int mismatch_count  = 0;
    int ticks_accepted  = 0;
    int results_checked = 0;
    int pickups_seen    = 0;
    int uprights_seen   = 0;
    int gen_budget      = 0;

    // Idling control shared by both sides, and the per-side gap bookkeeping.
    bit idle_on        = 1'b1;
    int src_gap        = 0;
    int src_calm       = 0;
    int sink_hold      = 0;
    int sink_calm      = 0;
    bit long_hold_done = 1'b0;

    function automatic int limit_drive(input int x, input int lim);
        if (x > lim)
        begin
            return lim;
        end
        if (x < -lim)
        begin
            return -lim;
        end
        return x;
    endfunction

    // Advances the shadow supervisor by one tick and returns the drives and flags that
    // the block must present for it. The steps run in the same order as in hardware:
    // mix and clamp, pick-up, put-down, on-end, upright drive, stop and halt.
    function automatic drive_out_t mix_and_supervise(input tick_in_t t);
        drive_out_t o;
        int         lim;
        int         base;
        int         l;
        int         r;
        int         p;
        int         rl;
        bit         was_lifted;
        bit         was_upright;
        lim         = int'(limit_cfg);
        base        = int'(t.balance) - int'(t.velocity);
        p           = int'(t.pitch);
        rl          = int'(t.roll);
        was_lifted  = lifted_st;
        was_upright = upright_st;
        // The left turn bit wins when both turn bits are set.
        if (t.cmd[LEFT_TURN_BIT])
        begin
            l = base;
            r = base + int'(t.turn);
        end
        else if (t.cmd[RIGHT_TURN_BIT])
        begin
            l = base - int'(t.turn);
            r = base;
        end
        else
        begin
            l = base + int'(t.turn);
            r = base - int'(t.turn);
        end
        l = limit_drive(l, lim);
        r = limit_drive(r, lim);
        // A saturated tick also drops the upright flag, even while standing upright.
        if (!lifted_st && ((l == lim && r == lim) || (l == -lim && r == -lim)))
        begin
            pickup_cnt = (pickup_cnt + 1) & COUNT_MASK;
            if (pickup_cnt > int'(pickup_cfg))
            begin
                stop_st    = 1'b1;
                lifted_st  = 1'b1;
                pickup_cnt = 0;
            end
            upright_st = 1'b0;
        end
        if (lifted_st && p < PITCH_LEVEL && p > -PITCH_LEVEL && rl > -ROLL_LEVEL
            && rl < ROLL_LEVEL)
        begin
            putdown_cnt = (putdown_cnt + 1) & COUNT_MASK;
            if (putdown_cnt > int'(putdown_cfg))
            begin
                stop_st     = 1'b0;
                lifted_st   = 1'b0;
                putdown_cnt = 0;
            end
        end
        if (lifted_st && !upright_st && (rl > ROLL_ON_END || rl < -ROLL_ON_END))
        begin
            upright_cnt = (upright_cnt + 1) & COUNT_MASK;
            if (upright_cnt > int'(upright_cfg))
            begin
                stop_st     = 1'b0;
                lifted_st   = 1'b0;
                upright_st  = 1'b1;
                upright_cnt = 0;
            end
        end
        if (upright_st && rl > ROLL_TILT)
        begin
            l       = int'(udrive_cfg);
            r       = 0;
            stop_st = 1'b0;
        end
        else if (upright_st && rl < -ROLL_TILT)
        begin
            l       = 0;
            r       = int'(udrive_cfg);
            stop_st = 1'b0;
        end
        // The halt latch from the previous tick zeroes this tick's drives.
        if (stop_st || halt_st)
        begin
            l = 0;
            r = 0;
        end
        if (t.cmd[HALT_CMD_BIT])
        begin
            l       = 0;
            r       = 0;
            halt_st = 1'b1;
        end
        else
        begin
            halt_st = 1'b0;
        end
        if (lifted_st && !was_lifted)
        begin
            pickups_seen++;
        end
        if (upright_st && !was_upright)
        begin
            uprights_seen++;
        end
        o.left    = 16'(l);
        o.right   = 16'(r);
        o.stopped = stop_st;
        o.lifted  = lifted_st;
        o.upright = upright_st;
        return o;
    endfunction

    // Decides the length of the next idle burst for one side. Now and then a side
    // enters a calm stretch in which it does not idle at all.
    function automatic int pick_gap(input bit enabled, ref int calm);
        if (!enabled)
        begin
            return 0;
        end
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 5) == 0)
        begin
            return $urandom_range(1, MAX_IDLE);
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(20, 60);
        end
        return 0;
    endfunction

    function automatic tick_in_t directed_tick(input int b, input int v, input int t,
                                               input int p, input int r, input int c);
        tick_in_t d;
        d.balance  = 16'(b);
        d.velocity = 16'(v);
        d.turn     = 16'(t);
        d.pitch    = 12'(p);
        d.roll     = 12'(r);
        d.cmd      = 16'(c);
        return d;
    endfunction

    // Builds one random tick of the given flavor. The command word is fully random
    // apart from the halt bit, which is set on about one tick in sixteen.
    function automatic tick_in_t make_tick(input tick_kind_t kind);
        tick_in_t t;
        int       sgn;
        t.balance  = 16'($urandom);
        t.velocity = 16'($urandom);
        t.turn     = 16'($urandom);
        t.pitch    = 12'($urandom);
        t.roll     = 12'($urandom);
        t.cmd      = 16'($urandom);
        if ($urandom_range(0, 7) != 0)
        begin
            t.cmd[HALT_CMD_BIT] = 1'b0;
        end
        sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
        case (kind)
            GEN_SATURATE:
            begin
                t.balance  = 16'(sgn * int'($urandom_range(16000, 32767)));
                t.velocity = 16'(-sgn * int'($urandom_range(0, 16000)));
                t.turn     = 16'(int'($urandom_range(0, 4000)) - 2000);
                t.pitch    = 12'(int'($urandom_range(0, 3600)) - 1800);
                t.roll     = 12'(int'($urandom_range(0, 3600)) - 1800);
            end
            GEN_LEVEL:
            begin
                // The ranges reach one step past the level window on both sides.
                t.pitch = 12'(int'($urandom_range(0, 100)) - 50);
                t.roll  = 12'(int'($urandom_range(0, 200)) - 100);
            end
            GEN_ON_END:
            begin
                t.roll = 12'(sgn * int'($urandom_range(880, 1800)));
            end
            GEN_TILT:
            begin
                t.balance  = 16'(int'($urandom_range(0, 4000)) - 2000);
                t.velocity = 16'(int'($urandom_range(0, 4000)) - 2000);
                t.turn     = 16'(int'($urandom_range(0, 4000)) - 2000);
                t.roll     = 12'(sgn * int'($urandom_range(780, 1800)));
            end
            default:
            begin
            end
        endcase
        return t;
    endfunction

    // Length of a run meant to carry a counter just past its register setting.
    function automatic int run_len(input int ticks);
        int top;
        top = (ticks + 2 > 80) ? 80 : ticks + 2;
        return $urandom_range(1, top);
    endfunction

    // Queues a run of ticks of one flavor, with the odd noise tick breaking it up.
    task automatic push_run(input tick_kind_t kind, input int count);
        repeat (count)
        begin
            if (gen_budget > 0)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    tick_q.push_back(make_tick(GEN_NOISE));
                end
                else
                begin
                    tick_q.push_back(make_tick(kind));
                end
                gen_budget--;
            end
        end
    endtask

    // Most random traffic follows the life of the robot: driven hard until it counts
    // as picked up, then either set down level or stood on end and tilted so that the
    // single-wheel drive applies. Short bursts of pure noise are mixed in.
    task automatic queue_random(input int total);
        gen_budget = total;
        while (gen_budget > 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                push_run(GEN_NOISE, $urandom_range(1, 6));
            end
            else
            begin
                push_run(GEN_SATURATE, run_len(int'(pickup_cfg)));
                if ($urandom_range(0, 1) != 0)
                begin
                    push_run(GEN_LEVEL, run_len(int'(putdown_cfg)));
                end
                else
                begin
                    push_run(GEN_ON_END, run_len(int'(upright_cfg)));
                    push_run(GEN_TILT, $urandom_range(2, 25));
                end
            end
        end
    endtask

    // Waits until every queued tick has been taken and every result has been checked,
    // then lets the block settle.
    task automatic wait_for_drain();
        do
        begin
            @(posedge clk);
        end
        while (tick_q.size() != 0 || in_valid || drive_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write. The shadow copy follows only once the transfer has happened.
    task automatic write_reg(input logic [bmms_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [14:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bmms_pkg::CFG_DRIVE_LIMIT:   limit_cfg   = val;
            bmms_pkg::CFG_PICKUP_TICKS:  pickup_cfg  = val[9:0];
            bmms_pkg::CFG_PUTDOWN_TICKS: putdown_cfg = val[9:0];
            bmms_pkg::CFG_UPRIGHT_TICKS: upright_cfg = val[9:0];
            bmms_pkg::CFG_UPRIGHT_DRIVE: udrive_cfg  = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic write_all(input int lim, input int pick, input int put, input int up,
                             input int ud);
        write_reg(bmms_pkg::CFG_DRIVE_LIMIT, 15'(lim));
        write_reg(bmms_pkg::CFG_PICKUP_TICKS, 15'(pick));
        write_reg(bmms_pkg::CFG_PUTDOWN_TICKS, 15'(put));
        write_reg(bmms_pkg::CFG_UPRIGHT_TICKS, 15'(up));
        write_reg(bmms_pkg::CFG_UPRIGHT_DRIVE, 15'(ud));
    endtask

    task automatic run_phase(input int total, input bit idling);
        idle_on = idling;
        queue_random(total);
        wait_for_drain();
    endtask

    task automatic compare_field(input string name, input logic signed [15:0] want,
                                 input logic signed [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Input driver. A tick that transfers is run through the shadow supervisor at once,
    // so the expected results line up with the order in which the block takes them.
    // A stalled tick stays on the bus unchanged; gaps only open between transfers.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                drive_expect_q.push_back(mix_and_supervise(tick_on_bus));
                ticks_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (tick_q.size() > 0)
                begin
                    tick_on_bus = tick_q.pop_front();
                    balance_term  <= tick_on_bus.balance;
                    velocity_term <= tick_on_bus.velocity;
                    turn_term     <= tick_on_bus.turn;
                    pitch_angle   <= tick_on_bus.pitch;
                    roll_angle    <= tick_on_bus.roll;
                    command_word  <= tick_on_bus.cmd;
                    in_valid      <= 1'b1;
                    src_gap = pick_gap(idle_on, src_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and output stall. Each transfer is checked against the oldest
    // expectation. Once, well into the run, the output is held off for a long stretch
    // so that both pipeline stages fill and the input side has to stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    $display("%0t ns: expected no result, actual left %0d, right %0d",
                             $time, left_drive, right_drive);
                    mismatch_count++;
                end
                else
                begin
                    result_due = drive_expect_q.pop_front();
                    compare_field("left_drive", result_due.left, left_drive);
                    compare_field("right_drive", result_due.right, right_drive);
                    compare_field("stopped", 16'(result_due.stopped), 16'(stopped));
                    compare_field("lifted", 16'(result_due.lifted), 16'(lifted));
                    compare_field("upright", 16'(result_due.upright), 16'(upright));
                end
                results_checked++;
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && results_checked >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                sink_hold = LONG_HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                // The burst includes this cycle, so the count runs one short from here.
                sink_hold = pick_gap(idle_on, sink_calm);
                out_stall <= (sink_hold > 0);
                if (sink_hold > 0)
                begin
                    sink_hold--;
                end
            end
        end
    end

    // Main sequence. Each phase is followed by a full drain, so the sender always waits
    // for every result before the registers change.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks at the reset settings: field extremes, each mix, both turn bits,
        // exact saturation, the halt latch, and angles on and past every threshold.
        idle_on = 1'b1;
        tick_q.push_back(directed_tick(0, 0, 0, 0, 0, 0));
        tick_q.push_back(directed_tick(32767, -32768, 32767, 1800, 1800, 0));
        tick_q.push_back(directed_tick(-32768, 32767, -32768, -1800, -1800, 0));
        tick_q.push_back(directed_tick(1000, 200, 300, 49, 99, CMD_LEFT));
        tick_q.push_back(directed_tick(1000, 200, 300, -49, -99, CMD_RIGHT));
        tick_q.push_back(directed_tick(1000, 200, 300, 50, 100, CMD_LEFT | CMD_RIGHT));
        tick_q.push_back(directed_tick(5000, -3000, 500, -50, -100, 0));
        tick_q.push_back(directed_tick(100, 100, 100, 2047, -2048, CMD_HALT));
        tick_q.push_back(directed_tick(100, 100, 100, -2048, 2047, 0));
        tick_q.push_back(directed_tick(-7000, 0, 0, 891, 890, 0));
        tick_q.push_back(directed_tick(7000, 0, 0, -891, -890, 0));
        tick_q.push_back(directed_tick(7001, 0, 1, 800, 801, 'hFFFF));
        tick_q.push_back(directed_tick(0, 0, 0, -800, -801, CMD_HALT));
        tick_q.push_back(directed_tick(32767, 32767, -32768, 0, 0,
                                       CMD_LEFT | CMD_RIGHT | CMD_HALT));
        tick_q.push_back(directed_tick(-1, -1, -1, -1, -1, 'hFFFF));
        tick_q.push_back(directed_tick(12345, -12345, 1, 1, 1, CMD_LEFT));
        tick_q.push_back(directed_tick(-32768, -32768, 32767, 1799, -1799, CMD_RIGHT));
        tick_q.push_back(directed_tick(6999, 0, 0, 0, 0, 0));
        wait_for_drain();
        run_phase(120, 1'b1);

        // Short counters so that pick-up, put-down and upright mode all happen often.
        // The long output hold-off falls inside this phase.
        write_all(5000, 3, 2, 4, 32767);
        run_phase(200, 1'b1);

        // Zero limit: every drive clamps to zero and counts as saturated.
        write_all(0, 0, 0, 0, 0);
        run_phase(150, 1'b1);

        // Largest limit and pick-up. Bits above a ten-bit register drop on the write.
        write_all(32767, 'h7FFF, 'h7C05, 1, 1);
        run_phase(150, 1'b1);

        // Lowering the pick-up setting below a counter that has run up fires at once.
        // Writes to indexes without a register must change nothing.
        write_all(100, 6, 7, 3, 12345);
        write_reg(CFG_SPARE_LO, 15'h7FFF);
        write_reg(CFG_SPARE_HI, 15'h0000);
        run_phase(150, 1'b1);

        write_all($urandom_range(0, 32767), $urandom_range(0, 12), $urandom_range(0, 12),
                  $urandom_range(0, 12), $urandom_range(0, 32767));
        run_phase(150, 1'b1);

        // Last part at full rate on both sides. Idling stops first and any burst still
        // running on either side is let out before new ticks arrive.
        idle_on = 1'b0;
        write_all($urandom_range(1000, 9000), $urandom_range(0, 10), $urandom_range(0, 10),
                  $urandom_range(0, 10), $urandom_range(0, 32767));
        repeat (MAX_IDLE) @(posedge clk);
        run_phase(130, 1'b0);

        mismatch_count += drive_expect_q.size();
        $display("Covered %0d ticks and %0d checked results over seven register settings.",
                 ticks_accepted, results_checked);
        $display("The shadow supervisor saw %0d pick-ups and %0d entries into upright mode.",
                 pickups_seen, uprights_seen);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("Timed out with %0d results still owed.", drive_expect_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
